// File: hw/rtl/audio_multi_effect_unit_macros.svh
// Assertion macros shared by the audio multi-effect unit RTL
`ifndef AUDIO_MULTI_EFFECT_UNIT_MACROS_SVH
`define AUDIO_MULTI_EFFECT_UNIT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds
`define AMFX_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds
`define AMFX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/amfx_pkg.sv
// Shared constants for the audio multi-effect unit
package amfx_pkg;

    localparam int SAMPLE_W = 16;

    // Configuration register widths
    localparam int MODE_W   = 2;
    localparam int WLEN_W   = 7;
    localparam int GAIN_W   = 6;
    localparam int CLIP_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL    = 2'd3;

    // Effect modes
    localparam logic [MODE_W-1:0] MODE_PASS    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AVERAGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISTORT = 2'd2;

    // Reset values
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_PASS;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 6'd5;
    localparam logic [CLIP_W-1:0] CLIP_RESET = 15'd27000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// File: hw/rtl/audio_multi_effect_unit.sv
// Top level of the audio multi-effect unit: history ring, control and effects
//
// One signed 16-bit sample in, one processed sample out. The history is a ring
// of MAX_WINDOW sample cells; every accepted sample shifts in at the head. In
// pass-through and distortion modes a result is registered in res_reg, then
// moved into the output register. In moving-average mode the ring is rotated
// once around while the newest window_length samples are summed, then a
// bit-serial divider works out the quotient one bit at a time. One sample is in
// work at a time and the input stalls until its result has moved into the output
// register, which a stalled output register can hold back. A finished result
// waits in the output register while the next sample is accepted. The history
// cells clear at reset.
module audio_multi_effect_unit #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [amfx_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [amfx_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [amfx_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [amfx_pkg::SAMPLE_W-1:0] sample_out
);
    import amfx_pkg::*;

    `include "audio_multi_effect_unit_macros.svh"

    localparam int N_W    = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W  = $clog2(MAX_WINDOW);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int ADD_W  = N_W + 1;
    localparam int EXT_W  = (N_W > WLEN_W) ? N_W : WLEN_W;
    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_DIVS = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    // Configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [WLEN_W-1:0] wlen_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [CLIP_W-1:0] clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            wlen_reg <= WLEN_RESET;
            gain_reg <= GAIN_RESET;
            clip_reg <= CLIP_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_EFFECT_MODE:   mode_reg <= cfg_wdata[MODE_W-1:0];
                REG_WINDOW_LENGTH: wlen_reg <= cfg_wdata[WLEN_W-1:0];
                REG_DRIVE_GAIN:    gain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_CLIP_LEVEL:    clip_reg <= cfg_wdata[CLIP_W-1:0];
                default:           mode_reg <= mode_reg;
            endcase
        end
    end

    // Effective window: zero counts as one, long windows saturate
    logic [EXT_W-1:0] wlen_ext;
    logic [N_W-1:0]   eff_n;

    always_comb
    begin
        wlen_ext = EXT_W'(wlen_reg);
        if (wlen_ext == '0)
        begin
            eff_n = N_W'(1);
        end
        else if (wlen_ext > EXT_W'(MAX_WINDOW))
        begin
            eff_n = N_W'(MAX_WINDOW);
        end
        else
        begin
            eff_n = wlen_ext[N_W-1:0];
        end
    end

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] rot_reg,   rot_next;
    logic             accept;
    logic             out_free;
    logic             out_valid_reg;
    logic             sum_last;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign sum_last = (state_reg == ST_SUM) && (rot_reg == CNT_W'(MAX_WINDOW - 1));

    // History ring: head takes the new sample on a transfer, the tail otherwise
    sample_t cell_q [MAX_WINDOW];
    sample_t head_din;
    logic    ring_shift;

    assign ring_shift = accept || (state_reg == ST_SUM);
    assign head_din   = accept ? sample_t'(sample_in) : cell_q[MAX_WINDOW-1];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                amfx_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (ring_shift),
                    .din   (head_din),
                    .dout  (cell_q[gi])
                );
            end
            else
            begin : g_body
                amfx_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (ring_shift),
                    .din   (cell_q[gi-1]),
                    .dout  (cell_q[gi])
                );
            end
        end
    endgenerate

    // Window sum: the tail shows oldest first, the newest N come last
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic                    in_window;

    assign in_window = (ADD_W'(rot_reg) + ADD_W'(eff_n)) >= ADD_W'(MAX_WINDOW);

    // Divider on the sum magnitude
    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;
    logic [SUM_W-1:0] sum_mag;
    logic             neg_reg, neg_next;

    assign sum_mag   = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
    assign div_start = (state_reg == ST_DIVS);

    amfx_div #(
        .DVD_W (SUM_W),
        .DVS_W (N_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (eff_n),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Distortion: scale and hard-clip
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] clip_pos;
    logic signed [PROD_W-1:0] clip_neg;
    sample_t                  dist_res;

    assign prod     = PROD_W'(sample_in) * $signed(PROD_W'(gain_reg));
    assign clip_pos = $signed(PROD_W'(clip_reg));
    assign clip_neg = -clip_pos;

    always_comb
    begin
        if (prod > clip_pos)
        begin
            dist_res = sample_t'(clip_pos);
        end
        else if (prod < clip_neg)
        begin
            dist_res = sample_t'(clip_neg);
        end
        else
        begin
            dist_res = sample_t'(prod);
        end
    end

    // Sequence one sample through the chosen effect
    sample_t res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        rot_next   = rot_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode_reg)
                        MODE_AVERAGE:
                        begin
                            acc_next   = '0;
                            rot_next   = '0;
                            state_next = ST_SUM;
                        end
                        MODE_DISTORT:
                        begin
                            res_next   = dist_res;
                            state_next = ST_HOLD;
                        end
                        default:
                        begin
                            res_next   = sample_t'(sample_in);
                            state_next = ST_HOLD;
                        end
                    endcase
                end
            end
            ST_SUM:
            begin
                if (in_window)
                begin
                    acc_next = acc_reg + SUM_W'(cell_q[MAX_WINDOW-1]);
                end
                rot_next = rot_reg + 1'b1;
                if (sum_last)
                begin
                    rot_next   = '0;
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                neg_next   = acc_reg[SUM_W-1];
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = neg_reg ? sample_t'(-div_quo) : sample_t'(div_quo);
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rot_reg   <= rot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    // Output register: load a finished result, drop valid after a transfer
    logic    out_valid_next;
    sample_t out_data_reg;
    logic    out_load;

    assign out_load = (state_reg == ST_HOLD) && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

    // Checks on sequencing
    `AMFX_ASSERT_SAME(a_rot_idle, state_reg != ST_SUM, rot_reg == '0, "ring counter left running")
    `AMFX_ASSERT_SAME(a_div_in_wait, div_done, state_reg == ST_DIV, "divider done outside wait")
    `AMFX_ASSERT_NEXT(a_sum_to_div, sum_last, state_reg == ST_DIVS, "sum pass missed divider")
    `AMFX_ASSERT_SAME(a_out_from_hold, $rose(out_valid_reg), $past(state_reg) == ST_HOLD,
                      "result appeared without a finished sample")

endmodule

// File: hw/rtl/amfx_cell.sv
// One sample cell of the circulating history line
module amfx_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  amfx_pkg::sample_t din,
    output amfx_pkg::sample_t dout
);
    import amfx_pkg::*;

    sample_t data_reg;

    // Take the neighbor's sample on every shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (shift)
        begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

// File: hw/rtl/amfx_div.sv
// Restoring unsigned divider, one quotient bit per cycle
module amfx_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    import amfx_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVS_W:0]   rem_reg,  rem_next;
    logic [DVD_W-1:0] quo_reg,  quo_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;

    // Shift in the next dividend bit and try one subtraction
    always_comb
    begin
        shifted = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
        diff    = shifted - {1'b0, divisor};
        fits    = (shifted >= {1'b0, divisor});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff : shifted;
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: tb/audio_multi_effect_unit_test.sv
// Self-checking testbench for the audio multi-effect unit: directed cases, then random traffic
module audio_multi_effect_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import amfx_pkg::*;

    localparam int WINDOW_MAX = 64;
    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = REG_EFFECT_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    sample_t sample_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    sample_t sample_out;

    // Shadow copy of the block's registers and history ring
    sample_t ring [WINDOW_MAX];
    int unsigned ring_head;
    logic [MODE_W-1:0] cur_mode;
    logic [WLEN_W-1:0] cur_window;
    logic [GAIN_W-1:0] cur_gain;
    logic [CLIP_W-1:0] cur_clip;

    sample_t effect_out_q [$];
    int error_count = 0;

    // Traffic shaping knobs
    bit sender_bursty = 1'b0;
    bit receiver_stalls = 1'b0;
    int unsigned burst_left = 0;
    int unsigned stall_run = 0;

    audio_multi_effect_unit #(
        .MAX_WINDOW(WINDOW_MAX)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample_in(sample_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_out(sample_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Store the sample in the ring, then compute the effect output for it
    function automatic sample_t apply_effect(input sample_t x);
        int acc;
        int taps;
        int pos;
        int y;
        int k;
        ring[ring_head] = x;
        case (cur_mode)
            MODE_AVERAGE:
            begin
                if (cur_window == 0)
                    taps = 1;
                else if (cur_window > WINDOW_MAX)
                    taps = WINDOW_MAX;
                else
                    taps = int'(cur_window);
                acc = 0;
                pos = ring_head;
                for (k = 0; k < taps; k++)
                begin
                    acc += int'(ring[pos]);
                    pos = (pos == 0) ? WINDOW_MAX - 1 : pos - 1;
                end
                y = acc / taps;
            end
            MODE_DISTORT:
            begin
                y = int'(x) * int'(cur_gain);
                if (y > int'(cur_clip))
                    y = int'(cur_clip);
                else if (y < -int'(cur_clip))
                    y = -int'(cur_clip);
            end
            default:
                y = int'(x);
        endcase
        ring_head = (ring_head + 1) % WINDOW_MAX;
        return sample_t'(y);
    endfunction

    // Send one sample, honoring the burst pattern, and record its expected output
    task automatic send_sample(input sample_t x);
        int unsigned gap;
        if (sender_bursty && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        sample_in <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        effect_out_q.push_back(apply_effect(x));
    endtask

    // Drop valid and hold until every expected output has been transferred
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (effect_out_q.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; leave the enable high unless this is the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit last);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_EFFECT_MODE: cur_mode = data[MODE_W-1:0];
            REG_WINDOW_LENGTH: cur_window = data[WLEN_W-1:0];
            REG_DRIVE_GAIN: cur_gain = data[GAIN_W-1:0];
            REG_CLIP_LEVEL: cur_clip = data[CLIP_W-1:0];
            default: ;
        endcase
        if (last)
            cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] mode,
                             input logic [CFG_DATA_W-1:0] window,
                             input logic [CFG_DATA_W-1:0] gain,
                             input logic [CFG_DATA_W-1:0] clip);
        wait_idle();
        write_reg(REG_EFFECT_MODE, mode, 1'b0);
        write_reg(REG_WINDOW_LENGTH, window, 1'b0);
        write_reg(REG_DRIVE_GAIN, gain, 1'b0);
        write_reg(REG_CLIP_LEVEL, clip, 1'b1);
    endtask

    // Receiver: alternate stall and flow runs of random length
    always @(posedge clk)
    begin
        if (!receiver_stalls)
        begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run == 0)
        begin
            out_stall <= !out_stall;
            stall_run <= out_stall ? $urandom_range(0, 11) : $urandom_range(0, 7);
        end
        else
            stall_run <= stall_run - 1;
    end

    // Compare each transferred output with the oldest expectation
    always @(posedge clk)
    begin : check_output
        sample_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (effect_out_q.size() == 0)
            begin
                $display("%0t: unexpected sample_out, expected none, got %0d",
                         $time, sample_out);
                error_count++;
            end
            else
            begin
                want = effect_out_q.pop_front();
                if (sample_out !== want)
                begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, want, sample_out);
                    error_count++;
                end
            end
        end
    end

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0: return sample_t'(32767);
            1: return sample_t'(-32768);
            2: return sample_t'(int'($urandom_range(0, 600)) - 300);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Occasionally fill the bits above the register width with noise
    function automatic logic [CFG_DATA_W-1:0] pad_upper(input logic [CFG_DATA_W-1:0] v,
                                                        input int w);
        logic [CFG_DATA_W-1:0] keep;
        keep = (CFG_DATA_W'(1) << w) - 1'b1;
        if ($urandom_range(0, 3) == 0)
            return (CFG_DATA_W'($urandom) & ~keep) | (v & keep);
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_window();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return WINDOW_MAX;
            3: return CFG_DATA_W'($urandom_range(WINDOW_MAX + 1, 2 ** WLEN_W - 1));
            default: return CFG_DATA_W'($urandom_range(1, WINDOW_MAX));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 32;
            3: return 2 ** GAIN_W - 1;
            default: return CFG_DATA_W'($urandom_range(0, 32));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_clip();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 32767;
            default: return CFG_DATA_W'($urandom_range(0, 32767));
        endcase
    endfunction

    // Average right after reset: empty history counts as zeros, then reset gain and clip
    task automatic test_power_up_defaults();
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_AVERAGE), 1'b1);
        send_sample(sample_t'(1000));
        send_sample(sample_t'(-2000));
        send_sample(sample_t'(32767));
        send_sample(sample_t'(-32768));
        wait_idle();
        write_reg(REG_EFFECT_MODE, CFG_DATA_W'(MODE_DISTORT), 1'b1);
        send_sample(sample_t'(6000));
        send_sample(sample_t'(-100));
    endtask

    task automatic test_pass_through();
        configure(CFG_DATA_W'(MODE_PASS), 16, 5, 27000);
        send_sample(sample_t'(32767));
        send_sample(sample_t'(-32768));
        send_sample(sample_t'(0));
        send_sample(sample_t'(-1));
    endtask

    // Window of one, truncation toward zero on negative sums, full window
    task automatic test_moving_average();
        configure(CFG_DATA_W'(MODE_AVERAGE), 1, 5, 27000);
        send_sample(sample_t'(12345));
        send_sample(sample_t'(-7));
        configure(CFG_DATA_W'(MODE_AVERAGE), 2, 5, 27000);
        send_sample(sample_t'(-1));
        send_sample(sample_t'(-2));
        send_sample(sample_t'(3));
        configure(CFG_DATA_W'(MODE_AVERAGE), WINDOW_MAX, 5, 27000);
        send_sample(sample_t'(32767));
        send_sample(sample_t'(-32768));
    endtask

    // Gain extremes, clip level at both ends
    task automatic test_distortion();
        configure(CFG_DATA_W'(MODE_DISTORT), 16, 32, 32767);
        send_sample(sample_t'(32767));
        send_sample(sample_t'(-32768));
        configure(CFG_DATA_W'(MODE_DISTORT), 16, 0, 32767);
        send_sample(sample_t'(1234));
        configure(CFG_DATA_W'(MODE_DISTORT), 16, 7, 0);
        send_sample(sample_t'(-500));
        configure(CFG_DATA_W'(MODE_DISTORT), 16, 2 ** GAIN_W - 1, 1000);
        send_sample(sample_t'(15));
        send_sample(sample_t'(-40));
    endtask

    // Unused mode, zero window and oversized window
    task automatic test_odd_settings();
        configure(CFG_DATA_W'(MODE_SPARE), 16, 5, 27000);
        send_sample(sample_t'(4321));
        send_sample(sample_t'(-32768));
        configure(CFG_DATA_W'(MODE_AVERAGE), 0, 5, 27000);
        send_sample(sample_t'(-9));
        configure(CFG_DATA_W'(MODE_AVERAGE), 2 ** WLEN_W - 1, 5, 27000);
        send_sample(sample_t'(100));
    endtask

    // Phases of random settings, pacing and samples
    task automatic test_random_traffic();
        int sent;
        int unsigned phase_len;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            configure(pad_upper(CFG_DATA_W'($urandom_range(0, 3)), MODE_W),
                      pad_upper(pick_window(), WLEN_W),
                      pad_upper(pick_gain(), GAIN_W),
                      pick_clip());
            sender_bursty = ($urandom_range(0, 2) != 0);
            receiver_stalls = ($urandom_range(0, 2) != 0);
            phase_len = $urandom_range(20, 80);
            repeat (phase_len)
            begin
                send_sample(random_sample());
                sent++;
            end
        end
    endtask

    initial
    begin
        ring_head = 0;
        foreach (ring[i])
            ring[i] = '0;
        cur_mode = MODE_RESET;
        cur_window = WLEN_RESET;
        cur_gain = GAIN_RESET;
        cur_clip = CLIP_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_power_up_defaults();
        test_pass_through();
        test_moving_average();
        test_distortion();
        test_odd_settings();
        test_random_traffic();

        // Drain, then hold a while to catch stray outputs
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #30ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
